### hdl/kps_pkg.sv
package kps_pkg;

    localparam int MAX_PARTS = 16;
    localparam int PART_W    = 4;
    localparam int CNT_W     = 17;
    localparam int MAX_BATCH = 65536;
    localparam int KEY_W     = 64;
    localparam int DIV_CNT_W = 7;

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_BOUND = 2'd1;
    localparam logic [1:0] OP_BATCH = 2'd2;

    localparam logic [1:0] MODE_RANGE = 2'd0;
    localparam logic [1:0] MODE_MOD   = 2'd1;
    localparam logic [1:0] MODE_EV    = 2'd2;

    localparam logic [9:0] EV_MODULUS = 10'd1000;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word
        logic bound_wr;    // write boundary
        logic clr_cnt;     // clear counters
        logic div_start;   // start divider with latched operands
        logic div_step;    // one divider step
        logic ev_setup;    // reload divider for second EV pass
        logic scan_start;  // reset range scan
        logic scan_step;   // test one partition
        logic finish;      // compute result and update counter
    } kps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic scan_done;
    } kps_sts_t;

endpackage

### hdl/kps_ctrl.sv
module kps_ctrl
    import kps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [1:0] mode_reg_in,
    input  logic       m_valid,
    input  logic       m_ready,
    output logic       m_set,
    output kps_cmd_t   cmd,
    input  kps_sts_t   sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EV2  = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_KEY;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        m_set      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = s_op;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (op_reg == OP_BOUND) begin
                    cmd.bound_wr = 1'b1;
                    state_next   = ST_IDLE;
                end else if (op_reg == OP_BATCH) begin
                    cmd.clr_cnt = 1'b1;
                    state_next  = ST_IDLE;
                end else if (op_reg != OP_KEY) begin
                    state_next = ST_IDLE;
                end else if (mode_reg_in == MODE_RANGE) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (mode_reg_in == MODE_MOD || mode_reg_in == MODE_EV) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = (mode_reg_in == MODE_EV) ? ST_EV2 : ST_FIN;
                end
            end
            ST_EV2: begin
                cmd.ev_setup = 1'b1;
                state_next   = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid || m_ready) begin
                    cmd.finish = 1'b1;
                    m_set      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### hdl/kps_dp.sv
module kps_dp
    import kps_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  kps_cmd_t                cmd,
    output kps_sts_t                sts,
    input  logic [1:0]              mode,
    input  logic [4:0]              partition_count,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic [PART_W-1:0]       s_bound_index,
    input  logic signed [KEY_W-1:0] s_bound_value,
    output logic                    res_selected,
    output logic [PART_W-1:0]       res_part_id,
    output logic [15:0]             res_slot,
    output logic signed [KEY_W-1:0] res_mapped_key,
    output logic                    res_overflow
);

    logic [KEY_W-1:0]  key_reg;
    logic [PART_W-1:0] bidx_reg;
    logic [KEY_W-1:0]  bval_reg;
    logic [KEY_W-1:0]  bounds_reg [MAX_PARTS];
    logic [CNT_W-1:0]  cnt_reg [MAX_PARTS];

    // restoring divider on magnitudes
    logic [KEY_W-1:0]     quo_reg;
    logic [KEY_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [DIV_CNT_W-1:0] dlast_reg;
    logic                 neg_reg;
    logic [9:0]           divisor_reg;

    logic [4:0]        n_eff;
    logic [KEY_W:0]    trial;
    logic [KEY_W-1:0]  rem_shift;

    logic [PART_W-1:0] scan_reg;
    logic              scan_done_reg;
    logic              rsel_reg;
    logic [PART_W-1:0] rpart_reg;
    logic [KEY_W-1:0]  rlo_reg;
    logic signed [KEY_W-1:0] lo_s, hi_s;
    logic [4:0]        scan_nxt;

    logic              sel_c;
    logic [PART_W-1:0] part_c;
    logic [KEY_W-1:0]  map_c;
    logic [KEY_W-1:0]  neg_rem;

    always_comb begin
        n_eff = partition_count;
        if (n_eff == 5'd0) n_eff = 5'd1;
        if (n_eff > 5'(MAX_PARTS)) n_eff = 5'(MAX_PARTS);
    end

    assign rem_shift = {rem_reg[KEY_W-2:0], quo_reg[KEY_W-1]};
    assign trial     = {1'b0, rem_shift} - {{(KEY_W-9){1'b0}}, divisor_reg};
    assign sts.div_last = (dcnt_reg == dlast_reg);

    // range scan: compare one partition per cycle
    assign lo_s = (scan_reg == '0) ? '0 : $signed(bounds_reg[scan_reg - 1'b1]);
    assign hi_s = $signed(bounds_reg[scan_reg]);
    assign scan_nxt = {1'b0, scan_reg} + 5'd1;
    assign sts.scan_done = scan_done_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= s_key;
            bidx_reg <= s_bound_index;
            bval_reg <= s_bound_value;
        end
        if (cmd.bound_wr) begin
            bounds_reg[bidx_reg] <= bval_reg;
        end
        if (cmd.div_start) begin
            neg_reg     <= key_reg[KEY_W-1];
            quo_reg     <= key_reg[KEY_W-1] ? (~key_reg + 1'b1) : key_reg;
            rem_reg     <= '0;
            dcnt_reg    <= '0;
            dlast_reg   <= DIV_CNT_W'(KEY_W - 1);
            divisor_reg <= (mode == MODE_EV) ? EV_MODULUS : {5'd0, n_eff};
        end else if (cmd.ev_setup) begin
            // remainder magnitude < 1000: ten more steps by n
            quo_reg     <= {rem_reg[9:0], {(KEY_W-10){1'b0}}};
            rem_reg     <= '0;
            dcnt_reg    <= '0;
            dlast_reg   <= DIV_CNT_W'(9);
            divisor_reg <= {5'd0, n_eff};
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!trial[KEY_W]) begin
                rem_reg <= trial[KEY_W-1:0];
                quo_reg <= {quo_reg[KEY_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[KEY_W-2:0], 1'b0};
            end
        end
        if (cmd.scan_start) begin
            scan_reg      <= '0;
            scan_done_reg <= 1'b0;
            rsel_reg      <= 1'b0;
        end else if (cmd.scan_step && !scan_done_reg) begin
            if ($signed(key_reg) >= lo_s && $signed(key_reg) < hi_s) begin
                rsel_reg      <= 1'b1;
                rpart_reg     <= scan_reg;
                rlo_reg       <= lo_s;
                scan_done_reg <= 1'b1;
            end else if (scan_nxt >= n_eff) begin
                scan_done_reg <= 1'b1;
            end else begin
                scan_reg <= scan_nxt[PART_W-1:0];
            end
        end
    end

    // result selection; a negative nonzero remainder selects nothing
    assign neg_rem = ~quo_reg + 1'b1;
    always_comb begin
        sel_c  = 1'b0;
        part_c = '0;
        map_c  = '0;
        if (mode == MODE_RANGE) begin
            sel_c  = rsel_reg;
            part_c = rpart_reg;
            map_c  = key_reg - rlo_reg;
        end else if (mode == MODE_MOD) begin
            sel_c  = !(neg_reg && rem_reg != '0);
            part_c = rem_reg[PART_W-1:0];
            map_c  = neg_reg ? neg_rem : quo_reg;
        end else if (mode == MODE_EV) begin
            sel_c  = !(neg_reg && rem_reg != '0);
            part_c = rem_reg[PART_W-1:0];
            map_c  = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PARTS; i++) cnt_reg[i] <= '0;
        end else if (cmd.clr_cnt) begin
            for (int i = 0; i < MAX_PARTS; i++) cnt_reg[i] <= '0;
        end else if (cmd.finish && sel_c && cnt_reg[part_c] < CNT_W'(MAX_BATCH)) begin
            cnt_reg[part_c] <= cnt_reg[part_c] + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_selected   <= sel_c;
            res_part_id    <= sel_c ? part_c : '0;
            res_mapped_key <= sel_c ? map_c : '0;
            if (!sel_c) begin
                res_slot     <= '0;
                res_overflow <= 1'b0;
            end else if (cnt_reg[part_c] >= CNT_W'(MAX_BATCH)) begin
                res_slot     <= 16'hFFFF;
                res_overflow <= 1'b1;
            end else begin
                res_slot     <= cnt_reg[part_c][15:0];
                res_overflow <= 1'b0;
            end
        end
    end

endmodule

### hdl/key_partition_select_unit.sv
// Channel   Dir  Handshake           Payload
// s_        in   s_valid / s_ready   s_op, s_key, s_bound_index, s_bound_value
// m_        out  m_valid / m_ready   m_selected, m_part_id, m_slot, m_mapped_key, m_overflow
// cfg_      in   cfg_we              cfg_index, cfg_wdata
//
// One word at a time: a new word is accepted only once the previous one is done. Boundary
// write and batch start are handled in the dispatch state. A key in mod mode goes through
// the 64-step serial divider, in EV mode through 64 steps by 1000, then 10 steps by the
// count, and in range mode through a scan that tests one partition per cycle.
// aresetn is synchronous, active low: mode 1, count 1, counters cleared.
// A result waits in the output register; the block stalls only if a new
// result is due while the previous one has not been taken.
module key_partition_select_unit
    import kps_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic [PART_W-1:0]       s_bound_index,
    input  logic signed [KEY_W-1:0] s_bound_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_selected,
    output logic [PART_W-1:0]       m_part_id,
    output logic [15:0]             m_slot,
    output logic signed [KEY_W-1:0] m_mapped_key,
    output logic                    m_overflow,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [4:0]              cfg_wdata
);

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    logic [1:0] mode_reg;
    logic [4:0] count_reg;
    logic       m_valid_reg;
    logic       m_set;
    kps_cmd_t   cmd;
    kps_sts_t   sts;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MOD;
            count_reg <= 5'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_wdata[1:0];
                CFG_COUNT: count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // output word valid: set on finish, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_set) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    assign m_valid = m_valid_reg;

    kps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .mode_reg_in (mode_reg),
        .m_valid     (m_valid_reg),
        .m_ready     (m_ready),
        .m_set       (m_set),
        .cmd         (cmd),
        .sts         (sts)
    );

    kps_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (mode_reg),
        .partition_count (count_reg),
        .s_key           (s_key),
        .s_bound_index   (s_bound_index),
        .s_bound_value   (s_bound_value),
        .res_selected    (m_selected),
        .res_part_id     (m_part_id),
        .res_slot        (m_slot),
        .res_mapped_key  (m_mapped_key),
        .res_overflow    (m_overflow)
    );

endmodule

### tb/key_partition_select_unit_test.sv
`timescale 1ns / 100ps
module key_partition_select_unit_test;
    import kps_pkg::*;

    // Codes the package leaves out: the unused op and the unused mode.
    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] MODE_NONE = 2'd3;
    // Register indexes of the configuration port.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [63:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;

    // One result word as the block should present it.
    typedef struct {
        logic        sel;
        logic [3:0]  part;
        logic [15:0] slot;
        logic [63:0] mkey;
        logic        ovf;
    } route_t;

    // One row of the directed table: the setting it runs under, the word,
    // and optionally a result typed in by hand.
    typedef struct {
        logic [1:0]  mode;
        logic [4:0]  count;
        logic [1:0]  op;
        logic [63:0] key;
        logic [3:0]  idx;
        logic [63:0] val;
        bit          typed;
        route_t      want;
    } row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_op;
    logic signed [KEY_W-1:0] s_key;
    logic [PART_W-1:0]       s_bound_index;
    logic signed [KEY_W-1:0] s_bound_value;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_selected;
    logic [PART_W-1:0]       m_part_id;
    logic [15:0]             m_slot;
    logic signed [KEY_W-1:0] m_mapped_key;
    logic                    m_overflow;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [4:0]              cfg_wdata;

    key_partition_select_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_bound_index (s_bound_index),
        .s_bound_value (s_bound_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_selected    (m_selected),
        .m_part_id     (m_part_id),
        .m_slot        (m_slot),
        .m_mapped_key  (m_mapped_key),
        .m_overflow    (m_overflow),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Predictor state: our own copy of the bounds, counters and registers.
    longint      bound_tab [MAX_PARTS];
    logic [16:0] fill_cnt  [MAX_PARTS];
    logic [1:0]  cur_mode;
    logic [4:0]  cur_count;

    route_t pending_routes[$];   // results still owed by the block, oldest first
    int     miss_count  = 0;
    bit     quiet       = 0;     // no idling on either side while set
    int     stall_asked = 0;     // long receiver hold-offs requested
    int     stall_given = 0;     // long receiver hold-offs started
    int     stall_left  = 0;
    route_t no_route;
    row_t   dir_rows[$];

    // Clock: 4 ns period.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Backstop: end the run if the block hangs.
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_miss(string what, logic [63:0] got, logic [63:0] want);
        miss_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    // Work out the result of one key against the current state and
    // advance the counter of the chosen partition.
    function automatic route_t route_key(longint key);
        route_t r;
        int     n;
        int     p;
        longint lo;
        longint rem;
        bit     hit;
        r   = '{default: '0};
        hit = 0;
        n   = (cur_count == 0) ? 1 : (cur_count > MAX_PARTS ? MAX_PARTS : cur_count);
        case (cur_mode)
            MODE_RANGE: begin
                // Lowest matching partition wins when bounds overlap.
                for (p = 0; p < n && !hit; p++) begin
                    lo = (p > 0) ? bound_tab[p-1] : 64'sd0;
                    if (key >= lo && key < bound_tab[p]) begin
                        hit    = 1;
                        r.part = p[3:0];
                        r.mkey = key - lo;   // wraps mod 2^64
                    end
                end
            end
            MODE_MOD: begin
                rem = key % longint'(n);
                if (rem >= 0) begin
                    hit    = 1;
                    r.part = rem[3:0];
                    r.mkey = key / longint'(n);
                end
            end
            MODE_EV: begin
                rem = (key % longint'(EV_MODULUS)) % longint'(n);
                if (rem >= 0) begin
                    hit    = 1;
                    r.part = rem[3:0];
                    r.mkey = key;
                end
            end
            default: hit = 0;   // unused mode selects nothing
        endcase
        if (hit) begin
            r.sel = 1'b1;
            if (fill_cnt[r.part] >= MAX_BATCH) begin
                // saturated: counter holds, slot pinned
                r.slot = 16'hFFFF;
                r.ovf  = 1'b1;
            end else begin
                r.slot = fill_cnt[r.part][15:0];
                fill_cnt[r.part]++;
            end
        end
        return r;
    endfunction

    // Apply one accepted word to the predictor and queue its result.
    task automatic log_word(logic [1:0] op, logic [63:0] key, logic [3:0] idx,
                            logic [63:0] val, bit typed, route_t want);
        route_t r;
        case (op)
            OP_KEY: begin
                r = route_key(key);
                pending_routes.push_back(typed ? want : r);
            end
            OP_BOUND: bound_tab[idx] = val;
            OP_BATCH: foreach (fill_cnt[i]) fill_cnt[i] = '0;
            default: ;   // unused op is dropped
        endcase
    endtask

    // Offer one word, idling first at random; return at the edge it is taken.
    task automatic push_word(logic [1:0] op, logic [63:0] key, logic [3:0] idx,
                             logic [63:0] val, bit typed, route_t want);
        int gap;
        gap = (quiet || $urandom_range(99) >= 27) ? 0 : $urandom_range(1, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_key         <= key;
        s_bound_index <= idx;
        s_bound_value <= val;
        do @(posedge aclk); while (!s_ready);
        log_word(op, key, idx, val, typed, want);
    endtask

    // Stop offering words and let the block run dry.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_cfg(logic [1:0] mode, logic [4:0] count);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= {3'b000, mode};
        @(posedge aclk);
        cur_mode  = mode;
        cfg_index <= REG_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cur_count = count;
        cfg_we    <= 1'b0;
    endtask

    // Load an ascending set of bounds; sometimes spread over the whole key
    // range so that the subtraction of the lower bound wraps.
    task automatic load_ramp();
        longint base;
        longint step;
        if ($urandom_range(3) == 0) begin
            base = KEY_MIN + 10;
            step = longint'(1) << 60;
        end else begin
            base = longint'($urandom_range(2000)) - 1000;
            step = $urandom_range(1, 400);
        end
        for (int i = 0; i < MAX_PARTS; i++)
            push_word(OP_BOUND, '0, i[3:0], base + step * i, 0, no_route);
    endtask

    // Keys: mostly near the bounds (range) or near zero, plus noise and extremes.
    function automatic logic [63:0] pick_key();
        int b;
        b = $urandom_range(15);
        case ($urandom_range(9))
            0, 1: return {$urandom, $urandom};
            2: begin
                case ($urandom_range(3))
                    0: return KEY_MAX;
                    1: return KEY_MIN;
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: begin
                if (cur_mode == MODE_RANGE)
                    return bound_tab[b] + longint'($urandom_range(8)) - 4;
                return longint'($urandom_range(6000)) - 3000;
            end
        endcase
    endfunction

    function automatic logic [63:0] pick_bound(logic [3:0] idx);
        if ($urandom_range(4) == 0) return {$urandom, $urandom};
        return bound_tab[idx] + longint'($urandom_range(100)) - 50;
    endfunction

    task automatic add_row(logic [1:0] mode, logic [4:0] count, logic [1:0] op,
                           logic [63:0] key, logic [3:0] idx, logic [63:0] val,
                           bit typed, logic sel, logic [15:0] slot, logic [63:0] mkey);
        row_t w;
        w.mode  = mode;
        w.count = count;
        w.op    = op;
        w.key   = key;
        w.idx   = idx;
        w.val   = val;
        w.typed = typed;
        w.want  = '{sel: sel, part: 4'd0, slot: slot, mkey: mkey, ovf: 1'b0};
        dir_rows.push_back(w);
    endtask

    // Receiver: random hold-offs, or one long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_asked != stall_given) begin
            stall_given <= stall_asked;
            stall_left  <= 400;
            m_ready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    // Check each taken result against the oldest owed one.
    always @(posedge aclk) begin : watch
        route_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_routes.size() == 0) begin
                report_miss("result with nothing owed", m_mapped_key, '0);
            end else begin
                w = pending_routes.pop_front();
                if (m_selected !== w.sel)   report_miss("selected", m_selected, w.sel);
                if (m_part_id !== w.part)   report_miss("part_id", m_part_id, w.part);
                if (m_slot !== w.slot)      report_miss("slot", m_slot, w.slot);
                if (m_mapped_key !== w.mkey) report_miss("mapped_key", m_mapped_key, w.mkey);
                if (m_overflow !== w.ovf)   report_miss("overflow", m_overflow, w.ovf);
            end
        end
    end

    initial begin : stim
        logic [1:0] mode_set  [11] = '{MODE_RANGE, MODE_MOD, MODE_EV, MODE_RANGE, MODE_MOD,
                                       MODE_EV, MODE_NONE, MODE_RANGE, MODE_MOD, MODE_EV,
                                       MODE_RANGE};
        logic [4:0] count_set [11] = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd7, 5'd31, 5'd5, 5'd0,
                                       5'd3, 5'd16, 5'd9};
        logic [1:0] op;
        logic [3:0] idx;
        int         roll;

        no_route      = '{default: '0};
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_KEY;
        s_key         = '0;
        s_bound_index = '0;
        s_bound_value = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MODE;
        cfg_wdata     = '0;
        cur_mode      = MODE_MOD;
        cur_count     = 5'd1;
        foreach (bound_tab[i]) bound_tab[i] = 0;
        foreach (fill_cnt[i])  fill_cnt[i]  = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Write every bound first so range mode never
        // reads one that was never loaded; the top one is the key maximum.
        for (int i = 0; i < MAX_PARTS; i++)
            push_word(OP_BOUND, '0, i[3:0],
                      (i == MAX_PARTS - 1) ? KEY_MAX : 64'(100 * (i + 1)), 0, no_route);

        // Reset setting: one partition, so every key lands in partition 0.
        add_row(MODE_MOD, 1, OP_KEY, '0, 0, 0, 1, 1, 0, '0);
        add_row(MODE_MOD, 1, OP_KEY, KEY_MAX, 0, 0, 1, 1, 1, KEY_MAX);
        add_row(MODE_MOD, 1, OP_KEY, KEY_MIN, 0, 0, 1, 1, 2, KEY_MIN);
        add_row(MODE_MOD, 1, OP_NONE, '1, 4'hF, '1, 0, 0, 0, '0);
        add_row(MODE_MOD, 1, OP_BATCH, '0, 0, 0, 0, 0, 0, '0);
        add_row(MODE_MOD, 1, OP_KEY, '1, 0, 0, 1, 1, 0, '1);
        // Negative remainder selects nothing.
        add_row(MODE_MOD, 16, OP_KEY, -64'sd17, 0, 0, 1, 0, 0, '0);
        add_row(MODE_MOD, 16, OP_KEY, 64'd35, 0, 0, 0, 0, 0, '0);
        // Count of zero acts as one, count above the maximum as the maximum.
        add_row(MODE_MOD, 0, OP_KEY, 64'd9, 0, 0, 0, 0, 0, '0);
        add_row(MODE_MOD, 31, OP_KEY, '1, 0, 0, 1, 0, 0, '0);
        add_row(MODE_MOD, 31, OP_KEY, 64'd4097, 0, 0, 0, 0, 0, '0);
        add_row(MODE_EV, 7, OP_KEY, 64'd123456, 0, 0, 0, 0, 0, '0);
        add_row(MODE_EV, 7, OP_KEY, -64'sd5, 0, 0, 1, 0, 0, '0);
        add_row(MODE_EV, 16, OP_KEY, KEY_MAX, 0, 0, 0, 0, 0, '0);
        add_row(MODE_NONE, 16, OP_KEY, 64'd42, 0, 0, 1, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, '0, 0, 0, 0, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, '1, 0, 0, 1, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, KEY_MAX, 0, 0, 1, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, 64'd1550, 0, 0, 0, 0, 0, '0);
        // Overlap: partition 4 now starts at 50, below partition 0's top.
        add_row(MODE_RANGE, 16, OP_BOUND, '0, 4'd3, 64'd50, 0, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, 64'd60, 0, 0, 0, 0, 0, '0);
        add_row(MODE_RANGE, 16, OP_KEY, 64'd450, 0, 0, 0, 0, 0, '0);
        add_row(MODE_RANGE, 1, OP_KEY, 64'd100, 0, 0, 1, 0, 0, '0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cur_mode || dir_rows[i].count != cur_count)
                set_cfg(dir_rows[i].mode, dir_rows[i].count);
            push_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].idx, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: a run of settings, extremes among them.
        for (int ph = 0; ph < 11; ph++) begin
            set_cfg(mode_set[ph], count_set[ph]);
            if (mode_set[ph] == MODE_RANGE) load_ramp();
            if (ph == 1) stall_asked++;   // fill the block and stall its input
            for (int k = 0; k < 65; k++) begin
                if (ph == 4 && k == 40) settle();   // sender waits for all results
                roll = $urandom_range(99);
                idx  = 4'($urandom_range(15));
                op   = (roll < 82) ? OP_KEY : (roll < 92) ? OP_BOUND :
                       (roll < 97) ? OP_BATCH : OP_NONE;
                push_word(op, pick_key(), idx, pick_bound(idx), 0, no_route);
            end
        end

        // Quiet stretch: one wide partition, no idling on either side.
        set_cfg(MODE_RANGE, 5'd1);
        push_word(OP_BOUND, '0, 4'd0, KEY_MAX, 0, no_route);
        push_word(OP_BATCH, '0, 4'd0, '0, 0, no_route);
        quiet = 1;
        repeat (60)
            push_word(OP_KEY, 64'($urandom_range(100000)), 4'd0, '0, 0, no_route);
        quiet = 0;

        // Drain and finish.
        s_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (miss_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hdl/kps_pkg.sv
hdl/kps_ctrl.sv
hdl/kps_dp.sv
hdl/key_partition_select_unit.sv
tb/key_partition_select_unit_test.sv
